// ===== hdl/cbx_pkg.sv =====
// Shared types and constants for the ChaCha20 block XOR engine.
`default_nettype none
package cbx_pkg;
    localparam int MAX_ROUNDS_DEF = 20;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;
    localparam int RC_W           = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY0      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LO  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HI  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS    = 3'd6;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    typedef logic [31:0] t_word;
    typedef t_word [15:0] t_state;

    typedef struct packed {
        logic [31:0] block_counter;
        logic [63:0] data_0;
        logic [63:0] data_1;
        logic [63:0] data_2;
        logic [63:0] data_3;
        logic [63:0] data_4;
        logic [63:0] data_5;
        logic [63:0] data_6;
        logic [63:0] data_7;
    } t_in_item;

    typedef struct packed {
        logic [63:0] out_0;
        logic [63:0] out_1;
        logic [63:0] out_2;
        logic [63:0] out_3;
        logic [63:0] out_4;
        logic [63:0] out_5;
        logic [63:0] out_6;
        logic [63:0] out_7;
    } t_out_item;

    // one quarter-round cell's four words
    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
    } t_quad;

    function automatic t_word rotl(input t_word v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction
endpackage
`default_nettype wire

// ===== hdl/cbx_if.sv =====
// Valid/ready channel carrying one item of a given payload type.
`default_nettype none
interface cbx_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/chacha20_block_xor_top.sv =====
// Top level: config registers, round sequencer, final add and XOR.
// Flow: after accept the sequencer runs the rounds (rounds saturated
//   to MAX_ROUNDS), then an end-of-count step, then a registered add/XOR.
// One item at a time: the next item is taken only after the last result is
//   registered; a result waiting on the output holds the core.
// Reset (synchronous, active low): key and nonce cleared, rounds = 20, idle.
`default_nettype none
module chacha20_block_xor_top #(
    parameter int MAX_ROUNDS = cbx_pkg::MAX_ROUNDS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire [cbx_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [cbx_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    cbx_if.sink                               in_ch,
    cbx_if.source                             out_ch
);
    import cbx_pkg::*;
    localparam int CNT_W = $clog2(MAX_ROUNDS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } t_st;

    logic [63:0] r_key [4];
    logic [63:0] r_nonce_lo;
    logic [31:0] r_nonce_hi;
    logic [RC_W-1:0] r_rounds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) r_key[k] <= '0;
            r_nonce_lo <= '0;
            r_nonce_hi <= '0;
            r_rounds   <= RC_W'(20);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3:
                    r_key[i_cfg_idx[1:0]] <= i_cfg_data;
                CFG_NONCE_LO: r_nonce_lo <= i_cfg_data;
                CFG_NONCE_HI: r_nonce_hi <= i_cfg_data[31:0];
                CFG_ROUNDS:   r_rounds   <= i_cfg_data[RC_W-1:0];
                default: ;
            endcase
        end
    end

    t_st r_st, n_st;
    logic [CNT_W-1:0] r_cnt, n_cnt, w_lim;
    logic r_ovld, n_ovld;
    t_state r_init;
    t_in_item r_item;
    t_out_item r_out;
    t_state w_core;
    logic w_acc, w_load, w_run;

    assign w_lim = (32'(r_rounds) > 32'(MAX_ROUNDS)) ? CNT_W'(MAX_ROUNDS)
                                                   : CNT_W'(r_rounds);
    assign in_ch.ready = (r_st == ST_IDLE);
    assign w_acc  = in_ch.valid && in_ch.ready;
    assign w_load = w_acc;
    assign w_run  = (r_st == ST_RUN) && (r_cnt != w_lim);

    t_state w_init;
    always_comb begin
        w_init[0] = SIGMA0; w_init[1] = SIGMA1; w_init[2] = SIGMA2; w_init[3] = SIGMA3;
        for (int k = 0; k < 4; k++) begin
            w_init[4 + 2 * k] = r_key[k][31:0];
            w_init[5 + 2 * k] = r_key[k][63:32];
        end
        w_init[12] = in_ch.payload.block_counter;
        w_init[13] = r_nonce_lo[31:0];
        w_init[14] = r_nonce_lo[63:32];
        w_init[15] = r_nonce_hi;
    end

    cbx_core u_core (
        .i_clk   (i_clk),
        .i_load  (w_load),
        .i_run   (w_run),
        .i_diag  (r_cnt[0]),
        .i_init  (w_init),
        .o_state (w_core)
    );

    t_state w_ks;
    always_comb begin
        for (int k = 0; k < 16; k++) w_ks[k] = w_core[k] + r_init[k];
    end

    always_comb begin
        n_st = r_st;
        n_cnt = r_cnt;
        n_ovld = r_ovld;
        if (out_ch.valid && out_ch.ready) n_ovld = 1'b0;
        unique case (r_st)
            ST_IDLE: if (w_acc) begin
                n_st = ST_RUN;
                n_cnt = '0;
            end
            ST_RUN: begin
                if (r_cnt == w_lim) n_st = ST_FIN;
                else n_cnt = r_cnt + 1'b1;
            end
            ST_FIN: if (!n_ovld) begin
                n_st = ST_IDLE;
                n_ovld = 1'b1;
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_cnt <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_st <= n_st;
            r_cnt <= n_cnt;
            r_ovld <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_init <= w_init;
            r_item <= in_ch.payload;
        end
        if (r_st == ST_FIN && n_st == ST_IDLE) begin
            r_out.out_0 <= r_item.data_0 ^ {w_ks[1], w_ks[0]};
            r_out.out_1 <= r_item.data_1 ^ {w_ks[3], w_ks[2]};
            r_out.out_2 <= r_item.data_2 ^ {w_ks[5], w_ks[4]};
            r_out.out_3 <= r_item.data_3 ^ {w_ks[7], w_ks[6]};
            r_out.out_4 <= r_item.data_4 ^ {w_ks[9], w_ks[8]};
            r_out.out_5 <= r_item.data_5 ^ {w_ks[11], w_ks[10]};
            r_out.out_6 <= r_item.data_6 ^ {w_ks[13], w_ks[12]};
            r_out.out_7 <= r_item.data_7 ^ {w_ks[15], w_ks[14]};
        end
    end

    assign out_ch.valid = r_ovld;
    assign out_ch.payload = r_out;
endmodule
`default_nettype wire

// ===== hdl/cbx_qr_cell.sv =====
// One quarter-round cell: holds four state words, applies a quarter round.
`default_nettype none
module cbx_qr_cell (
    input  wire          i_clk,
    input  wire          i_load,
    input  wire          i_run,
    input  cbx_pkg::t_quad i_load_q,
    input  cbx_pkg::t_quad i_q,
    output cbx_pkg::t_quad o_q
);
    import cbx_pkg::*;
    t_quad r_q;
    t_quad n_q;
    t_word a1, d1, c1, b1, a2, d2, c2, b2;

    always_comb begin
        a1 = i_q.a + i_q.b;
        d1 = rotl(i_q.d ^ a1, 16);
        c1 = i_q.c + d1;
        b1 = rotl(i_q.b ^ c1, 12);
        a2 = a1 + b1;
        d2 = rotl(d1 ^ a2, 8);
        c2 = c1 + d2;
        b2 = rotl(b1 ^ c2, 7);
        n_q = r_q;
        if (i_load) begin
            n_q = i_load_q;
        end else if (i_run) begin
            n_q = '{a: a2, b: b2, c: c2, d: d2};
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;
endmodule
`default_nettype wire

// ===== hdl/cbx_core.sv =====
// Row of four quarter-round cells with column/diagonal routing between them.
`default_nettype none
module cbx_core (
    input  wire             i_clk,
    input  wire             i_load,
    input  wire             i_run,
    input  wire             i_diag,
    input  cbx_pkg::t_state i_init,
    output cbx_pkg::t_state o_state
);
    import cbx_pkg::*;
    t_quad w_load [4];
    t_quad w_in   [4];
    t_quad w_out  [4];
    t_state w_s;
    logic r_diag;

    // cell j holds words j, 4+j, 8+j, 12+j in column order
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_s[j]      = w_out[j].a;
            w_s[4 + j]  = w_out[j].b;
            w_s[8 + j]  = w_out[j].c;
            w_s[12 + j] = w_out[j].d;
            w_load[j] = '{a: i_init[j], b: i_init[4 + j], c: i_init[8 + j],
                          d: i_init[12 + j]};
        end
        for (int j = 0; j < 4; j++) begin
            // diagonal round: cell j gets b from its right neighbor,
            // c two over, d three over; results land back in place
            if (i_diag) begin
                w_in[j] = '{a: w_s[j], b: w_s[4 + ((j + 1) % 4)],
                            c: w_s[8 + ((j + 2) % 4)], d: w_s[12 + ((j + 3) % 4)]};
            end else begin
                w_in[j] = '{a: w_s[j], b: w_s[4 + j], c: w_s[8 + j], d: w_s[12 + j]};
            end
        end
    end

    // cells hold the state unrotated; rerouting happens on the output side
    t_quad w_cell [4];
    t_quad w_fix  [4];
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_fix[j] = w_cell[j];
        end
        if (r_diag) begin
            for (int j = 0; j < 4; j++) begin
                w_fix[j].b = w_cell[(j + 3) % 4].b;
                w_fix[j].c = w_cell[(j + 2) % 4].c;
                w_fix[j].d = w_cell[(j + 1) % 4].d;
            end
        end
        for (int j = 0; j < 4; j++) begin
            w_out[j] = w_fix[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_diag <= 1'b0;
        end else if (i_run) begin
            r_diag <= i_diag;
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_cell
        cbx_qr_cell u_cell (
            .i_clk    (i_clk),
            .i_load   (i_load),
            .i_run    (i_run),
            .i_load_q (w_load[g]),
            .i_q      (w_in[g]),
            .o_q      (w_cell[g])
        );
    end

    assign o_state = w_s;
endmodule
`default_nettype wire

// ===== hdl/cbx_checker.sv =====
// Port-level checker for the ChaCha20 block XOR top level.
`default_nettype none
module cbx_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire in_valid,
    input wire in_ready,
    input wire out_valid,
    input wire out_ready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_no_accept_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready) else $error("second item taken while busy");
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> ##1 !$rose(out_valid)) else $error("result too early");
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid) else $error("valid after reset");
endmodule

bind chacha20_block_xor_top cbx_checker u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
);
`default_nettype wire
